// ===== sv/rdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_pkg
// shared widths, command and status types and the digit glyph function of the
// radix digit converter
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int VALUE_BITS    = 32;
    localparam int VALUE_W       = 32;
    localparam int RADIX_W       = 6;
    localparam int CHAR_W        = 7;
    localparam int COUNT_W       = 6;
    localparam int DIGIT_W       = 6;
    localparam int ADDR_W        = $clog2(VALUE_BITS);
    localparam int CNT_W         = $clog2(VALUE_BITS + 1);
    localparam int STEP_W        = $clog2(VALUE_BITS);
    localparam int S_TDATA_W     = 40;
    localparam int M_TDATA_W     = 16;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_LETTER = CHAR_W'(55);
    localparam logic [CHAR_W-1:0] CHAR_LAST   = CHAR_W'(90);

    // command from the controller to the datapath
    typedef struct packed {
        logic load;
        logic step;
        logic store;
        logic rd_start;
        logic rd_next;
    } rdc_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic div_done;
        logic quot_zero;
        logic store_full;
        logic rd_last;
    } rdc_status_t;

    // digit to ascii, 0-9 then A-Z
    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10)) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else if (d < DIGIT_W'(36)) begin
            c = CHAR_LETTER + CHAR_W'(d);
        end else begin
            c = CHAR_LAST;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== sv/radix_digit_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radix_digit_converter
// unsigned value to ascii digits in a radix from 2 to 36, most significant
// digit first
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one value and a radix per transaction; radix below 2
//   is taken as 2 and above 36 as 36. m_ channel returns one transaction per
//   digit, most significant first, m_tlast on the least significant one.
//   every character carries the total digit count; zero gives a single '0'.
// timing:
//   each digit takes 32 steps of the bit-serial divider plus a store step.
//   after the last digit is stored, a read step fetches the first character,
//   then one character follows per cycle while m_tready holds.
//   worst case is radix 2 with the top bit set: 32 digits.
//   s_tready is high only while idle; the next value is taken the cycle after
//   the last character has been accepted.
// reset and stall:
//   aresetn (synchronous, active low) returns to idle with no output pending.
//   a stalled m_ channel holds the current character and pauses the readout.
// ----------------------------------------------------------------------------
module radix_digit_converter (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // value [31:0], radix [37:32], zero [39:38]
    input  wire logic [rdc_pkg::S_TDATA_W-1:0] s_tdata,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // digit_char [6:0], digit_count [12:7], zero [15:13]
    output      logic [rdc_pkg::M_TDATA_W-1:0] m_tdata,
    output      logic                          m_tlast
);
    import rdc_pkg::*;

    rdc_cmd_t          cmd;
    rdc_status_t       st;
    logic [CHAR_W-1:0]  digit_char;
    logic [COUNT_W-1:0] digit_count;

    rdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    rdc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_tdata[VALUE_W-1:0]),
        .s_radix     (s_tdata[VALUE_W+RADIX_W-1:VALUE_W]),
        .cmd         (cmd),
        .st          (st),
        .digit_char  (digit_char),
        .digit_count (digit_count)
    );

    assign m_tdata = {{(M_TDATA_W - CHAR_W - COUNT_W){1'b0}}, digit_count, digit_char};
    assign m_tlast = st.rd_last;

endmodule
`default_nettype wire

// ===== sv/rdc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/rdc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_datapath
// bit-serial restoring divider by the radix, digit store and read-back
// ----------------------------------------------------------------------------
module rdc_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [rdc_pkg::VALUE_W-1:0]   s_value,
    input  wire logic [rdc_pkg::RADIX_W-1:0]   s_radix,
    input  wire rdc_pkg::rdc_cmd_t             cmd,
    output      rdc_pkg::rdc_status_t          st,
    output      logic [rdc_pkg::CHAR_W-1:0]    digit_char,
    output      logic [rdc_pkg::COUNT_W-1:0]   digit_count
);
    import rdc_pkg::*;

    logic [VALUE_BITS-1:0] quot_reg, quot_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [ADDR_W-1:0]     rd_idx_reg, rd_idx_next;

    logic [DIGIT_W:0]      trial;
    logic                  ge;
    logic [RADIX_W-1:0]    radix_clamped;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DIGIT_W-1:0]    rd_data;

    always_comb begin
        if (s_radix < RADIX_MIN) begin
            radix_clamped = RADIX_MIN;
        end else if (s_radix > RADIX_MAX) begin
            radix_clamped = RADIX_MAX;
        end else begin
            radix_clamped = s_radix;
        end
    end

    // one quotient bit per step
    assign trial = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign ge    = trial >= {1'b0, radix_reg};

    always_comb begin
        quot_next   = quot_reg;
        rem_next    = rem_reg;
        radix_next  = radix_reg;
        step_next   = step_reg;
        n_next      = n_reg;
        rd_idx_next = rd_idx_reg;
        rd_addr     = rd_idx_reg;
        if (cmd.load) begin
            quot_next  = s_value[VALUE_BITS-1:0];
            rem_next   = '0;
            radix_next = radix_clamped;
            step_next  = '0;
            n_next     = '0;
        end
        if (cmd.step) begin
            quot_next = {quot_reg[VALUE_BITS-2:0], ge};
            rem_next  = ge ? DIGIT_W'(trial - {1'b0, radix_reg}) : trial[DIGIT_W-1:0];
            step_next = step_reg + STEP_W'(1);
        end
        if (cmd.store) begin
            n_next    = n_reg + CNT_W'(1);
            rem_next  = '0;
            step_next = '0;
        end
        if (cmd.rd_start) begin
            rd_addr     = ADDR_W'(n_reg - CNT_W'(1));
            rd_idx_next = rd_addr;
        end
        if (cmd.rd_next) begin
            rd_addr     = rd_idx_reg - ADDR_W'(1);
            rd_idx_next = rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quot_reg   <= '0;
            n_reg      <= '0;
            step_reg   <= '0;
            rd_idx_reg <= '0;
        end else begin
            quot_reg   <= quot_next;
            n_reg      <= n_next;
            step_reg   <= step_next;
            rd_idx_reg <= rd_idx_next;
        end
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
    end

    rdc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_digit_store (
        .aclk    (aclk),
        .wr_en   (cmd.store),
        .wr_addr (n_reg[ADDR_W-1:0]),
        .wr_data (rem_reg),
        .rd_en   (cmd.rd_start | cmd.rd_next),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign st.div_done   = step_reg == STEP_W'(VALUE_BITS - 1);
    assign st.quot_zero  = quot_reg == '0;
    assign st.store_full = n_reg == CNT_W'(VALUE_BITS - 1);
    assign st.rd_last    = rd_idx_reg == '0;

    assign digit_char  = glyph(rd_data);
    assign digit_count = COUNT_W'(n_reg);

endmodule
`default_nettype wire

// ===== sv/rdc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_ctrl
// sequencer: accept, divide digit by digit, store, then play digits back
// ----------------------------------------------------------------------------
module rdc_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire rdc_pkg::rdc_status_t st,
    output      rdc_pkg::rdc_cmd_t    cmd
);
    import rdc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_SHOW  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (st.div_done) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                // zero quotient or full store ends the conversion, a value of zero still gives one digit
                if (st.quot_zero || st.store_full) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_READ: begin
                cmd.rd_start = 1'b1;
                state_next   = ST_SHOW;
            end
            ST_SHOW: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (st.rd_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/rdc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_checker
// port-level checks on the radix digit converter, bound to the top level
// ----------------------------------------------------------------------------
module rdc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [rdc_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);
    import rdc_pkg::*;

    // a stalled character holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transaction changed");

    // no new value is taken while characters are pending
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while output pending");

    // the divider takes cycles, so no character right after an input transaction
    a_no_early_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("character too early after input");

    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] >= 7'd48 && m_tdata[6:0] <= 7'd57) ||
                     (m_tdata[6:0] >= 7'd65 && m_tdata[6:0] <= 7'd90))
        else $error("character outside digit set");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[12:7] != 6'd0 && m_tdata[12:7] <= 6'(VALUE_BITS))
        else $error("digit count out of range");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
